>>> hw/rtl/nps_pkg.sv
`default_nettype none

package nps_pkg;

    // defaults for the top-level parameters
    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 16;

    // command codes (input tuser)
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // status codes (output tuser)
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // control that rides alongside each point through the scan pipe
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_nps_tag;

endpackage

`default_nettype wire

>>> hw/rtl/nps_store.sv
`default_nettype none

// Point memory: one write port, one registered read port.
module nps_store #(
    parameter int MAX_POINTS = nps_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF,
    localparam int IDX_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
    localparam int PT_W      = 2 * COORD_BITS
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_wr_en,
    input  wire [IDX_W-1:0]        i_wr_addr,
    input  wire [PT_W-1:0]         i_wr_data,
    input  wire [IDX_W-1:0]        i_rd_addr,
    input  nps_pkg::t_nps_tag      i_rd_tag,
    output logic [PT_W-1:0]        o_rd_data,
    output nps_pkg::t_nps_tag      o_rd_tag
);

    logic [PT_W-1:0]   r_mem [MAX_POINTS];
    logic [PT_W-1:0]   r_rd_data;
    nps_pkg::t_nps_tag r_rd_tag;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_tag <= '0;
        end else begin
            r_rd_tag <= i_rd_tag;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_tag  = r_rd_tag;

endmodule

`default_nettype wire

>>> hw/rtl/nps_dist_unit.sv
`default_nettype none

// Squared-distance unit, three stages: |diff|, square, sum.
module nps_dist_unit #(
    parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF,
    localparam int PT_W      = 2 * COORD_BITS,
    localparam int SQ_W      = 2 * COORD_BITS,
    localparam int DIST_W    = 2 * COORD_BITS + 1
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire [COORD_BITS-1:0]   i_q_x,
    input  wire [COORD_BITS-1:0]   i_q_y,
    input  wire [PT_W-1:0]         i_pt,
    input  nps_pkg::t_nps_tag      i_tag,
    output logic [PT_W-1:0]        o_pt,
    output logic [DIST_W-1:0]      o_dist,
    output nps_pkg::t_nps_tag      o_tag
);

    logic signed [COORD_BITS:0] w_diff_x;
    logic signed [COORD_BITS:0] w_diff_y;
    logic        [COORD_BITS:0] w_abs_x;
    logic        [COORD_BITS:0] w_abs_y;

    logic [COORD_BITS-1:0] r1_dx;
    logic [COORD_BITS-1:0] r1_dy;
    logic [PT_W-1:0]       r1_pt;
    logic [SQ_W-1:0]       r2_sx;
    logic [SQ_W-1:0]       r2_sy;
    logic [PT_W-1:0]       r2_pt;
    logic [DIST_W-1:0]     r3_dist;
    logic [PT_W-1:0]       r3_pt;

    nps_pkg::t_nps_tag r1_tag;
    nps_pkg::t_nps_tag r2_tag;
    nps_pkg::t_nps_tag r3_tag;

    // difference of two signed coords fits COORD_BITS+1 signed; magnitude fits COORD_BITS
    always_comb begin
        w_diff_x = signed'({i_pt[COORD_BITS-1], i_pt[COORD_BITS-1:0]})
                 - signed'({i_q_x[COORD_BITS-1], i_q_x});
        w_diff_y = signed'({i_pt[PT_W-1], i_pt[PT_W-1:COORD_BITS]})
                 - signed'({i_q_y[COORD_BITS-1], i_q_y});
        w_abs_x  = w_diff_x[COORD_BITS] ? unsigned'(-w_diff_x) : unsigned'(w_diff_x);
        w_abs_y  = w_diff_y[COORD_BITS] ? unsigned'(-w_diff_y) : unsigned'(w_diff_y);
    end

    always_ff @(posedge i_clk) begin
        r1_dx   <= w_abs_x[COORD_BITS-1:0];
        r1_dy   <= w_abs_y[COORD_BITS-1:0];
        r1_pt   <= i_pt;
        r2_sx   <= r1_dx * r1_dx;
        r2_sy   <= r1_dy * r1_dy;
        r2_pt   <= r1_pt;
        r3_dist <= {1'b0, r2_sx} + {1'b0, r2_sy};
        r3_pt   <= r2_pt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag <= '0;
            r2_tag <= '0;
            r3_tag <= '0;
        end else begin
            r1_tag <= i_tag;
            r2_tag <= r1_tag;
            r3_tag <= r2_tag;
        end
    end

    assign o_pt   = r3_pt;
    assign o_dist = r3_dist;
    assign o_tag  = r3_tag;

endmodule

`default_nettype wire

>>> hw/rtl/nearest_point_search.sv
`default_nettype none

// Results: clear, load and a query on an empty store give their result in the cycle after the
// request is taken; a query over N stored points gives it once its last point has passed
// the memory read register and the distance unit. One request at a time: a query holds the
// block until its scan ends, the read port and distance unit taking one stored point per cycle.
// Reset (synchronous, active low) empties the store and idles the block; memory not cleared.
module nearest_point_search #(
    parameter int MAX_POINTS = nps_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF,
    localparam int IDX_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
    localparam int CNT_W     = $clog2(MAX_POINTS + 1),
    localparam int PT_W      = 2 * COORD_BITS,
    localparam int DIST_W    = 2 * COORD_BITS + 1,
    localparam int IN_W      = ((PT_W + 7) / 8) * 8,
    localparam int OUT_W     = ((PT_W + DIST_W + 7) / 8) * 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    // request channel
    input  wire              i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire [IN_W-1:0]   i_s_axis_tdata,   // x_coord, y_coord, zero pad
    input  wire [1:0]        i_s_axis_tuser,   // cmd
    // result channel
    output logic             o_m_axis_tvalid,
    input  wire              i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata,   // closest_x, closest_y, distance_sq, zero pad
    output logic [1:0]       o_m_axis_tuser    // status
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic [CNT_W-1:0]      r_count, n_count;   // points held
    logic [CNT_W-1:0]      r_issue, n_issue;   // next entry to read during a scan
    logic [COORD_BITS-1:0] r_q_x, n_q_x;
    logic [COORD_BITS-1:0] r_q_y, n_q_y;
    logic [DIST_W-1:0]     r_best_d, n_best_d;
    logic [PT_W-1:0]       r_best_pt, n_best_pt;

    // output register
    logic                  r_m_valid, n_m_valid;
    logic [COORD_BITS-1:0] r_out_x, n_out_x;
    logic [COORD_BITS-1:0] r_out_y, n_out_y;
    logic [DIST_W-1:0]     r_out_d, n_out_d;
    logic [1:0]            r_out_st, n_out_st;

    logic                  w_accept;
    logic [1:0]            w_cmd;
    logic [COORD_BITS-1:0] w_in_x;
    logic [COORD_BITS-1:0] w_in_y;
    logic                  w_full;
    logic                  w_wr_en;
    logic                  w_issue;
    logic                  w_take;

    nps_pkg::t_nps_tag     w_rd_tag;
    nps_pkg::t_nps_tag     w_mem_tag;
    nps_pkg::t_nps_tag     w_dist_tag;
    logic [PT_W-1:0]       w_mem_pt;
    logic [PT_W-1:0]       w_dist_pt;
    logic [DIST_W-1:0]     w_dist_d;

    // a new request is taken only when idle and the result slot is free or draining
    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_m_valid || i_m_axis_tready);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_cmd  = i_s_axis_tuser;
    assign w_in_x = i_s_axis_tdata[COORD_BITS-1:0];
    assign w_in_y = i_s_axis_tdata[PT_W-1:COORD_BITS];

    assign w_full  = (r_count >= CNT_W'(MAX_POINTS));
    assign w_wr_en = w_accept && (w_cmd == nps_pkg::CMD_LOAD) && !w_full;

    // scan issue: one memory read per cycle, tagged first and last
    assign w_issue        = (r_state == S_SCAN) && (r_issue != r_count);
    assign w_rd_tag.valid = w_issue;
    assign w_rd_tag.first = (r_issue == '0);
    assign w_rd_tag.last  = (r_issue == (r_count - CNT_W'(1)));

    nps_store #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data ({w_in_y, w_in_x}),
        .i_rd_addr (r_issue[IDX_W-1:0]),
        .i_rd_tag  (w_rd_tag),
        .o_rd_data (w_mem_pt),
        .o_rd_tag  (w_mem_tag)
    );

    nps_dist_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_x   (r_q_x),
        .i_q_y   (r_q_y),
        .i_pt    (w_mem_pt),
        .i_tag   (w_mem_tag),
        .o_pt    (w_dist_pt),
        .o_dist  (w_dist_d),
        .o_tag   (w_dist_tag)
    );

    // strict less-than keeps the earliest point on a tie
    assign w_take = w_dist_tag.valid && (w_dist_tag.first || (w_dist_d < r_best_d));

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_issue   = r_issue;
        n_q_x     = r_q_x;
        n_q_y     = r_q_y;
        n_best_d  = r_best_d;
        n_best_pt = r_best_pt;
        n_m_valid = r_m_valid && !i_m_axis_tready;
        n_out_x   = r_out_x;
        n_out_y   = r_out_y;
        n_out_d   = r_out_d;
        n_out_st  = r_out_st;

        if (w_issue) begin
            n_issue = r_issue + CNT_W'(1);
        end

        if (w_take) begin
            n_best_d  = w_dist_d;
            n_best_pt = w_dist_pt;
        end

        if (w_accept) begin
            n_m_valid = 1'b1;
            n_out_x   = '0;
            n_out_y   = '0;
            n_out_d   = '0;
            n_out_st  = nps_pkg::ST_OK;
            unique case (w_cmd)
                nps_pkg::CMD_CLEAR: begin
                    n_count = '0;
                end
                nps_pkg::CMD_LOAD: begin
                    if (w_full) begin
                        n_out_st = nps_pkg::ST_FULL;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
                nps_pkg::CMD_QUERY: begin
                    if (r_count == '0) begin
                        n_out_st = nps_pkg::ST_EMPTY;
                    end else begin
                        // result comes at the end of the scan
                        n_m_valid = 1'b0;
                        n_state   = S_SCAN;
                        n_issue   = '0;
                        n_q_x     = w_in_x;
                        n_q_y     = w_in_y;
                    end
                end
                default: begin
                    // unused code: no state change, plain ok result
                end
            endcase
        end

        // last point out of the distance unit: publish the winner
        if (w_dist_tag.valid && w_dist_tag.last) begin
            n_state   = S_IDLE;
            n_m_valid = 1'b1;
            n_out_x   = n_best_pt[COORD_BITS-1:0];
            n_out_y   = n_best_pt[PT_W-1:COORD_BITS];
            n_out_d   = n_best_d;
            n_out_st  = nps_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_issue   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_issue   <= n_issue;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q_x     <= n_q_x;
        r_q_y     <= n_q_y;
        r_best_d  <= n_best_d;
        r_best_pt <= n_best_pt;
        r_out_x   <= n_out_x;
        r_out_y   <= n_out_y;
        r_out_d   <= n_out_d;
        r_out_st  <= n_out_st;
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = OUT_W'({r_out_d, r_out_y, r_out_x});
    assign o_m_axis_tuser  = r_out_st;

`ifndef ASSERT_OFF
    // nothing may leave the distance unit once the block is idle
    a_no_stray_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_dist_tag.valid)
        else $error("distance unit output while idle");

    // the fill count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store depth");

    // a finished query never overwrites a result still waiting
    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dist_tag.valid && w_dist_tag.last) |-> (!r_m_valid || i_m_axis_tready))
        else $error("query result would overwrite pending result");

    // a query request with points held produces no result in the next cycle
    a_query_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_cmd == nps_pkg::CMD_QUERY) && (r_count != '0))
        |=> (r_state == S_SCAN) && !r_m_valid)
        else $error("query did not enter scan");
`endif

endmodule

`default_nettype wire

>>> bench/nps_checker.sv
// Watches both channels of nearest_point_search, keeps its own copy of the point store,
// predicts every result and compares it field by field.
module nps_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_req_valid,
    input  wire        i_req_ready,
    input  wire [31:0] i_req_data,    // x_coord, y_coord
    input  wire [1:0]  i_req_cmd,     // cmd
    input  wire        i_res_valid,
    input  wire        i_res_ready,
    input  wire [71:0] i_res_data,    // closest_x, closest_y, distance_sq, zero pad
    input  wire [1:0]  i_res_status,  // status
    output int         o_fail_count,
    output int         o_pending,
    output int         o_results,
    output int         o_hits,
    output int         o_empty,
    output int         o_drops
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W = nps_pkg::COORD_BITS_DEF;
    localparam int DIST_W  = 2 * COORD_W + 1;
    localparam int DEPTH   = nps_pkg::MAX_POINTS_DEF;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [DIST_W-1:0]         dist_sq;
        logic [1:0]                status;
    } t_nearest_result;

    logic signed [COORD_W-1:0] stored_x [DEPTH];
    logic signed [COORD_W-1:0] stored_y [DEPTH];
    int                        stored_count;
    t_nearest_result           expected_q [$];

    // updates the shadow store and returns what the block must answer
    function automatic t_nearest_result apply_request(input logic [1:0] cmd,
                                                      input logic signed [COORD_W-1:0] qx,
                                                      input logic signed [COORD_W-1:0] qy);
        t_nearest_result r;
        longint          dx;
        longint          dy;
        longint          d;
        longint          best_d;
        int              best;
        r.x       = '0;
        r.y       = '0;
        r.dist_sq = '0;
        r.status  = nps_pkg::ST_OK;
        unique case (cmd)
            nps_pkg::CMD_CLEAR: begin
                stored_count = 0;
            end
            nps_pkg::CMD_LOAD: begin
                if (stored_count >= DEPTH) begin
                    r.status = nps_pkg::ST_FULL;
                end else begin
                    stored_x[stored_count] = qx;
                    stored_y[stored_count] = qy;
                    stored_count++;
                end
            end
            nps_pkg::CMD_QUERY: begin
                if (stored_count == 0) begin
                    r.status = nps_pkg::ST_EMPTY;
                end else begin
                    best   = 0;
                    best_d = 0;
                    for (int i = 0; i < stored_count; i++) begin
                        dx = longint'(stored_x[i]) - longint'(qx);
                        dy = longint'(stored_y[i]) - longint'(qy);
                        d  = dx * dx + dy * dy;
                        // strict compare: a tie keeps the earlier entry
                        if (i == 0 || d < best_d) begin
                            best   = i;
                            best_d = d;
                        end
                    end
                    r.x       = stored_x[best];
                    r.y       = stored_y[best];
                    r.dist_sq = best_d[DIST_W-1:0];
                end
            end
            default: ;  // unused code, no effect
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_results    = 0;
        o_hits       = 0;
        o_empty      = 0;
        o_drops      = 0;
        stored_count = 0;
    end

    always @(posedge i_clk) begin : monitor
        t_nearest_result want;
        t_nearest_result got;
        if (!i_rst_n) begin
            stored_count = 0;
            expected_q.delete();
        end else begin
            // results first: one cannot belong to a request taken at the same edge
            if (i_res_valid && i_res_ready) begin
                got.x       = i_res_data[COORD_W-1:0];
                got.y       = i_res_data[2*COORD_W-1:COORD_W];
                got.dist_sq = i_res_data[2*COORD_W+DIST_W-1:2*COORD_W];
                got.status  = i_res_status;
                o_results++;
                if (expected_q.size() == 0) begin
                    $error("result with nothing outstanding: x %0d y %0d dist %0d status %0d",
                           got.x, got.y, got.dist_sq, got.status);
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("closest_x", want.x, got.x);
                    check_field("closest_y", want.y, got.y);
                    check_field("distance_sq", longint'(want.dist_sq),
                                longint'(got.dist_sq));
                    check_field("status", want.status, got.status);
                    if (want.status == nps_pkg::ST_FULL) o_drops++;
                    else if (want.status == nps_pkg::ST_EMPTY) o_empty++;
                end
            end
            if (i_req_valid && i_req_ready) begin
                want = apply_request(i_req_cmd, i_req_data[COORD_W-1:0],
                                     i_req_data[2*COORD_W-1:COORD_W]);
                if (i_req_cmd == nps_pkg::CMD_QUERY && want.status == nps_pkg::ST_OK)
                    o_hits++;
                expected_q.push_back(want);
            end
        end
        o_pending = expected_q.size();
    end

endmodule

>>> bench/nearest_point_search_tb.sv
// Top of the nearest_point_search bench: clock, reset, request and result drivers,
// watchdog and verdict. All prediction and comparison lives in nps_checker.
module nearest_point_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W = nps_pkg::COORD_BITS_DEF;
    localparam int IN_W    = ((2 * COORD_W + 7) / 8) * 8;
    localparam int OUT_W   = ((4 * COORD_W + 1 + 7) / 8) * 8;

    // the block answers the fourth command code with a plain ok result and no state change
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

    localparam int REQUEST_TARGET = 1700;
    localparam int IDLE_PCT       = 16;
    // longest wait for one request is a full-store query plus a sink stall
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = nps_pkg::MAX_POINTS_DEF + 16;

    typedef enum {SPREAD_WIDE, SPREAD_CLUSTER, SPREAD_EDGE} t_spread;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;   // x_coord, y_coord
    logic [1:0]       s_tuser;   // cmd
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;   // closest_x, closest_y, distance_sq, zero pad
    logic [1:0]       m_tuser;   // status

    int fail_count;
    int pending_results;
    int results_seen;
    int query_hits;
    int empty_queries;
    int dropped_loads;

    int requests_sent;   // commands the block acts on; the unused code is not counted
    int stall_cycles;
    bit quiet_window;    // no idling on either side while set

    nearest_point_search dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    nps_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (s_tvalid),
        .i_req_ready  (s_tready),
        .i_req_data   (s_tdata[31:0]),
        .i_req_cmd    (s_tuser),
        .i_res_valid  (m_tvalid),
        .i_res_ready  (m_tready),
        .i_res_data   (m_tdata[71:0]),
        .i_res_status (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending_results),
        .o_results    (results_seen),
        .o_hits       (query_hits),
        .o_empty      (empty_queries),
        .o_drops      (dropped_loads)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: drop tready at random, never inside the quiet window
    always @(negedge clk) begin
        m_tready <= rst_n && (quiet_window || $urandom_range(0, 99) >= IDLE_PCT);
    end

    // watchdog: ends the run if nothing moves on either channel for too long
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     stall_cycles, pending_results);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [COORD_W-1:0] pick_coord(input t_spread spread);
        unique case (spread)
            SPREAD_CLUSTER: return COORD_W'(int'($urandom_range(0, 16)) - 8);
            SPREAD_EDGE: begin
                unique case ($urandom_range(0, 5))
                    0:       return COORD_MIN;
                    1:       return COORD_MIN + 1'b1;
                    2:       return '1;
                    3:       return '0;
                    4:       return COORD_W'(1);
                    default: return COORD_MAX;
                endcase
            end
            default: return COORD_W'($urandom);
        endcase
    endfunction

    // Called at a falling edge with nothing yet assigned in this step; returns at the
    // falling edge after the request is taken, tvalid still high.
    task automatic send_request(input logic [1:0] cmd, input logic [COORD_W-1:0] x,
                                input logic [COORD_W-1:0] y);
        while (!quiet_window && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({y, x});
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        if (cmd != CMD_UNUSED) requests_sent++;
    endtask

    // hold the request side low until every outstanding result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending_results != 0);
    endtask

    initial begin : stimulus
        t_spread spread;
        int      episode;
        int      n_loads;
        int      n_queries;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = nps_pkg::CMD_CLEAR;
        m_tready     = 1'b0;
        quiet_window = 1'b0;
        stall_cycles = 0;
        requests_sent = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed part ---
        send_request(nps_pkg::CMD_QUERY, '0, '0);       // empty store straight after reset
        send_request(CMD_UNUSED, '1, '1);               // no state change, store stays empty
        send_request(nps_pkg::CMD_QUERY, '1, '1);
        send_request(nps_pkg::CMD_LOAD, COORD_MIN, COORD_MIN);
        send_request(nps_pkg::CMD_QUERY, COORD_MAX, COORD_MAX);   // largest possible distance
        send_request(nps_pkg::CMD_QUERY, COORD_MIN, COORD_MIN);   // exact hit, distance zero
        send_request(nps_pkg::CMD_LOAD, COORD_MAX, COORD_MAX);
        send_request(nps_pkg::CMD_LOAD, COORD_MAX, COORD_MAX);    // duplicate entry
        send_request(nps_pkg::CMD_QUERY, COORD_MAX, COORD_MIN);
        send_request(nps_pkg::CMD_CLEAR, COORD_MAX, COORD_MAX);
        send_request(nps_pkg::CMD_QUERY, '0, '0);       // empty again after clear
        // equidistant points: the earliest must win
        send_request(nps_pkg::CMD_LOAD, COORD_W'(2), '0);
        send_request(nps_pkg::CMD_LOAD, COORD_W'(-2), '0);
        send_request(nps_pkg::CMD_LOAD, '0, COORD_W'(2));
        send_request(nps_pkg::CMD_QUERY, '0, '0);
        send_request(nps_pkg::CMD_QUERY, '0, COORD_W'(1));
        send_request(CMD_UNUSED, COORD_W'(1), COORD_W'(1));
        send_request(nps_pkg::CMD_QUERY, COORD_W'(1), COORD_W'(1));
        send_request(nps_pkg::CMD_CLEAR, '0, '0);
        send_request(nps_pkg::CMD_LOAD, COORD_MIN, COORD_MAX);
        send_request(nps_pkg::CMD_LOAD, COORD_MAX, COORD_MIN);
        send_request(nps_pkg::CMD_QUERY, '0, '0);       // tie across the opposite corners
        drain_results();

        // --- random part: mostly clear / fill / query episodes ---
        episode = 0;
        while (requests_sent < REQUEST_TARGET) begin
            quiet_window = (episode >= 30 && episode < 45);
            if (episode == 0 || $urandom_range(0, 99) < 80) begin
                spread = t_spread'($urandom_range(0, 2));
                // usually start afresh; sometimes pile onto what is already stored
                if (episode == 0 || $urandom_range(0, 3) != 0)
                    send_request(nps_pkg::CMD_CLEAR, pick_coord(SPREAD_WIDE),
                                 pick_coord(SPREAD_WIDE));
                if (episode == 0)
                    n_loads = nps_pkg::MAX_POINTS_DEF + 2;   // overflow the store early on
                else if ($urandom_range(0, 9) == 0)
                    n_loads = $urandom_range(nps_pkg::MAX_POINTS_DEF - 9,
                                             nps_pkg::MAX_POINTS_DEF + 6);
                else
                    n_loads = $urandom_range(1, 12);
                repeat (n_loads)
                    send_request(nps_pkg::CMD_LOAD, pick_coord(spread), pick_coord(spread));
                n_queries = $urandom_range(1, 6);
                repeat (n_queries) begin
                    if ($urandom_range(0, 3) == 0)
                        send_request(nps_pkg::CMD_QUERY, pick_coord(SPREAD_WIDE),
                                     pick_coord(SPREAD_WIDE));
                    else
                        send_request(nps_pkg::CMD_QUERY, pick_coord(spread),
                                     pick_coord(spread));
                end
            end else begin
                // noise: any command, any data
                repeat ($urandom_range(1, 6))
                    send_request(2'($urandom_range(0, 3)), pick_coord(SPREAD_WIDE),
                                 pick_coord(SPREAD_WIDE));
            end
            if (episode % 16 == 7) drain_results();
            episode++;
        end
        quiet_window = 1'b0;
        s_tvalid <= 1'b0;

        // wait out the last results, then give stray outputs a chance to show up
        while (pending_results != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("%0d requests over %0d episodes: %0d queries found a point,",
                 requests_sent, episode, query_hits);
        $display("%0d hit an empty store, %0d loads bounced off a full store; %0d checked",
                 empty_queries, dropped_loads, results_seen);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/nps_pkg.sv
hw/rtl/nps_store.sv
hw/rtl/nps_dist_unit.sv
hw/rtl/nearest_point_search.sv
bench/nps_checker.sv
bench/nearest_point_search_tb.sv
